// File: rtl/ddsam_pkg.sv
// shared constants and types for the am sideband synthesizer
package ddsam_pkg;

    localparam int PHASE_BITS  = 32;
    localparam int INDEX_BITS  = 10;
    localparam int TABLE_DEPTH = 1 << INDEX_BITS;
    localparam int STEP_W      = 32;
    localparam int ENTRY_W     = 12;
    localparam int SUM_W       = ENTRY_W + 2;
    localparam int SAMPLE_W    = 8;
    localparam int SHIFT       = 4;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    localparam logic [SAMPLE_W-1:0] SAMPLE_OFFSET = 8'd127;

    typedef enum logic [1:0] {
        CMD_TICK         = 2'd0,
        CMD_LOAD_CARRIER = 2'd1,
        CMD_LOAD_MOD     = 2'd2,
        CMD_RESTART      = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_CARRIER_STEP = 2'd0,
        REG_LOWER_STEP   = 2'd1,
        REG_UPPER_STEP   = 2'd2,
        REG_NONE         = 2'd3
    } reg_idx_t;

endpackage

// File: rtl/dds_am_sideband_synth_core.sv
// am sideband direct digital synthesizer: three phase accumulators and two wave tables
//
// input channel (in_valid / in_stall) carries one item per accepted cycle:
//   cmd tick produces one dac sample, load commands write table_value into the
//   carrier or modulation table at table_index, restart clears all three phases.
// output channel (out_valid / out_stall) carries one sample per tick item, in order.
// steps are written over the apb port (carrier 0x0, lower 0x4, upper 0x8); the user must
// do so only while idle, as the block itself does not enforce it. throughput: one item per
// cycle unless out_stall holds the pipeline. a tick's phases advance at the accept edge as it
// enters the read stage, the tables are read into the sum stage (registered memory read
// port), then sum and offset go into the output register.
// the carrier table has one read port, the modulation table two (both sidebands).
// when out_stall holds a sample, items keep flowing into empty stages behind it;
// load and restart items retire at the read stage and never wait on the output.
// reset clears phases, steps and pipeline valids; table contents are undefined
// until written and need no clearing pass.
module dds_am_sideband_synth_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [1:0]                             cmd,
    input  logic [9:0]                             table_index,
    input  logic signed [ddsam_pkg::ENTRY_W-1:0]   table_value,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [ddsam_pkg::SAMPLE_W-1:0]         sample,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [ddsam_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [ddsam_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [ddsam_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                   pready
);

    localparam int PB = ddsam_pkg::PHASE_BITS;
    localparam int IB = ddsam_pkg::INDEX_BITS;
    localparam int EW = ddsam_pkg::ENTRY_W;
    localparam int SW = ddsam_pkg::SUM_W;

    // configuration
    logic [ddsam_pkg::STEP_W-1:0] carrier_step_reg;
    logic [ddsam_pkg::STEP_W-1:0] lower_step_reg;
    logic [ddsam_pkg::STEP_W-1:0] upper_step_reg;
    ddsam_pkg::reg_idx_t          reg_sel;
    logic                         cfg_write;

    // phases
    logic [PB-1:0] carrier_phase_reg;
    logic [PB-1:0] lower_phase_reg;
    logic [PB-1:0] upper_phase_reg;

    // tables
    logic [EW-1:0] carrier_table_reg [ddsam_pkg::TABLE_DEPTH];
    logic [EW-1:0] mod_table_reg     [ddsam_pkg::TABLE_DEPTH];

    // read stage
    logic            s1_valid_reg;
    ddsam_pkg::cmd_t s1_cmd_reg;
    logic [IB-1:0]   s1_index_reg;
    logic [EW-1:0]   s1_value_reg;

    // sum stage
    logic          s2_valid_reg;
    logic [EW-1:0] carrier_rd_reg;
    logic [EW-1:0] lower_rd_reg;
    logic [EW-1:0] upper_rd_reg;

    // output register
    logic                          out_valid_reg;
    logic [ddsam_pkg::SAMPLE_W-1:0] sample_reg;

    ddsam_pkg::cmd_t in_cmd;
    logic            in_accept;
    logic            out_free;
    logic            s2_go;
    logic            s2_free;
    logic            s1_go;
    logic            s1_tick_go;
    logic [SW-1:0]   sum;

    // apb port
    assign pready    = 1'b1;
    assign reg_sel   = ddsam_pkg::reg_idx_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        unique case (reg_sel)
            ddsam_pkg::REG_CARRIER_STEP: prdata = carrier_step_reg;
            ddsam_pkg::REG_LOWER_STEP:   prdata = lower_step_reg;
            ddsam_pkg::REG_UPPER_STEP:   prdata = upper_step_reg;
            ddsam_pkg::REG_NONE:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carrier_step_reg <= '0;
            lower_step_reg   <= '0;
            upper_step_reg   <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                ddsam_pkg::REG_CARRIER_STEP: carrier_step_reg <= pwdata;
                ddsam_pkg::REG_LOWER_STEP:   lower_step_reg   <= pwdata;
                ddsam_pkg::REG_UPPER_STEP:   upper_step_reg   <= pwdata;
                ddsam_pkg::REG_NONE:         ;
            endcase
        end
    end

    // flow control: each stage moves when the stage ahead is empty or moving
    assign out_free   = !out_valid_reg || !out_stall;
    assign s2_go      = s2_valid_reg && out_free;
    assign s2_free    = !s2_valid_reg || out_free;
    assign s1_go      = s1_valid_reg && ((s1_cmd_reg != ddsam_pkg::CMD_TICK) || s2_free);
    assign s1_tick_go = s1_go && (s1_cmd_reg == ddsam_pkg::CMD_TICK);
    assign in_stall   = s1_valid_reg && !s1_go;
    assign in_accept  = in_valid && !in_stall;
    assign in_cmd     = ddsam_pkg::cmd_t'(cmd);

    // ticks step phases at accept, restart clears them; held while a tick is in the read stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carrier_phase_reg <= '0;
            lower_phase_reg   <= '0;
            upper_phase_reg   <= '0;
        end
        else if (in_accept)
        begin
            unique case (in_cmd)
                ddsam_pkg::CMD_TICK:
                begin
                    carrier_phase_reg <= carrier_phase_reg + PB'(carrier_step_reg);
                    lower_phase_reg   <= lower_phase_reg + PB'(lower_step_reg);
                    upper_phase_reg   <= upper_phase_reg + PB'(upper_step_reg);
                end
                ddsam_pkg::CMD_RESTART:
                begin
                    carrier_phase_reg <= '0;
                    lower_phase_reg   <= '0;
                    upper_phase_reg   <= '0;
                end
                ddsam_pkg::CMD_LOAD_CARRIER,
                ddsam_pkg::CMD_LOAD_MOD: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_cmd_reg   <= in_cmd;
            s1_index_reg <= IB'(table_index);
            s1_value_reg <= table_value;
        end
    end

    // items leave the read stage in order, so writes and reads never meet in one cycle
    always_ff @(posedge clk)
    begin
        if (s1_go && (s1_cmd_reg == ddsam_pkg::CMD_LOAD_CARRIER))
        begin
            carrier_table_reg[s1_index_reg] <= s1_value_reg;
        end
        if (s1_tick_go)
        begin
            carrier_rd_reg <= carrier_table_reg[carrier_phase_reg[PB-1 -: IB]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && (s1_cmd_reg == ddsam_pkg::CMD_LOAD_MOD))
        begin
            mod_table_reg[s1_index_reg] <= s1_value_reg;
        end
        if (s1_tick_go)
        begin
            lower_rd_reg <= mod_table_reg[lower_phase_reg[PB-1 -: IB]];
            upper_rd_reg <= mod_table_reg[upper_phase_reg[PB-1 -: IB]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s1_tick_go)
        begin
            s2_valid_reg <= 1'b1;
        end
        else if (s2_go)
        begin
            s2_valid_reg <= 1'b0;
        end
    end

    // carrier + lower - upper, sign extended to hold the full range
    assign sum = {{(SW-EW){carrier_rd_reg[EW-1]}}, carrier_rd_reg}
               + {{(SW-EW){lower_rd_reg[EW-1]}}, lower_rd_reg}
               - {{(SW-EW){upper_rd_reg[EW-1]}}, upper_rd_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_free)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // arithmetic shift then offset; only the low byte survives so the wrap is free
    always_ff @(posedge clk)
    begin
        if (s2_go)
        begin
            sample_reg <= sum[ddsam_pkg::SHIFT +: ddsam_pkg::SAMPLE_W]
                        + ddsam_pkg::SAMPLE_OFFSET;
        end
    end

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;

endmodule
